@@ hw/rtl/stc_pkg.sv @@
// Shared types and constants for the scope trigger capture block.
// Holds the request and response word layouts and the window and frame sizes.
// No dependencies.
`default_nettype none

package stc_pkg;

   localparam int WINDOW_LOG2 = 10;
   localparam int FRAME_LEN   = 100;
   localparam int SUM_W       = 8 + WINDOW_LOG2;

   typedef logic [1:0] channel_mode_type;

   localparam channel_mode_type MODE_CH1 = 2'd0;
   localparam channel_mode_type MODE_CH2 = 2'd1;
   localparam channel_mode_type MODE_ALT = 2'd2;

   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   typedef struct packed {
      logic [7:0] sample;
      logic       frame_taken;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       channel;
      logic [7:0] sample_index;
      logic [7:0] sample_value;
      logic       frame_last;
      logic [7:0] peak_to_peak;
      logic [7:0] average;
      logic       next_channel;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type word;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/stc_core.sv @@
// Per-sample measurement and trigger state for the scope trigger capture block.
// Depends on stc_pkg for word layouts and sizes.
`default_nettype none

module stc_core
   import stc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire req_type          req_word,
   input  wire logic             csr_wr_en,
   input  wire channel_mode_type csr_wr_data,
   output result_type            result
);

   typedef enum logic [2:0] {
      PH_MEASURE     = 3'd0,
      PH_AWAIT_FALL  = 3'd1,
      PH_AWAIT_RISE  = 3'd2,
      PH_AWAIT_LEVEL = 3'd3,
      PH_CAPTURE     = 3'd4
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [7:0]              prev_ff, prev_in;
   logic [7:0]              min_ff, min_in;
   logic [7:0]              max_ff, max_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [WINDOW_LOG2-1:0]  count_ff, count_in;
   logic [7:0]              level_ff, level_in;
   logic [7:0]              index_ff, index_in;
   logic                    pending_ff, pending_in;
   logic                    active_ff, active_in;
   channel_mode_type        mode_ff, mode_in;

   logic [7:0]              s;
   logic                    pending_v;
   logic [7:0]              min_v, max_v;
   logic [SUM_W-1:0]        sum_v;
   logic                    last_v;
   logic                    active_v;

   assign s = req_word.sample;

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      level_in   = level_ff;
      index_in   = index_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      mode_in    = mode_ff;
      result     = '0;

      pending_v = pending_ff & ~req_word.frame_taken;
      min_v     = (s < min_ff) ? s : min_ff;
      max_v     = (s > max_ff) ? s : max_ff;
      sum_v     = sum_ff + SUM_W'(s);
      last_v    = ({1'b0, index_ff} + 9'd1) >= 9'(FRAME_LEN);
      active_v  = (mode_ff == MODE_ALT) ? ~active_ff : active_ff;

      if (accept) begin
         pending_in = pending_v;
         case (phase_ff)
            PH_MEASURE: begin
               prev_in = s;
               if (count_ff == '1) begin
                  result.push              = 1'b1;
                  result.word.kind         = KIND_MEASURE;
                  result.word.channel      = active_ff;
                  result.word.peak_to_peak = max_v - min_v;
                  result.word.average      = sum_v[WINDOW_LOG2 +: 8];
                  result.word.next_channel = active_ff;
                  level_in = sum_v[WINDOW_LOG2 +: 8];
                  min_in   = 8'hFF;
                  max_in   = 8'h00;
                  sum_in   = '0;
                  count_in = '0;
                  phase_in = PH_AWAIT_FALL;
               end else begin
                  min_in   = min_v;
                  max_in   = max_v;
                  sum_in   = sum_v;
                  count_in = count_ff + 1'b1;
               end
            end
            PH_AWAIT_FALL: begin
               if (s < prev_ff) phase_in = PH_AWAIT_RISE;
               prev_in = s;
            end
            PH_AWAIT_RISE: begin
               if (s > prev_ff) phase_in = PH_AWAIT_LEVEL;
               prev_in = s;
            end
            PH_AWAIT_LEVEL: begin
               if (s > level_ff) begin
                  phase_in = PH_CAPTURE;
                  index_in = '0;
               end
            end
            PH_CAPTURE: begin
               prev_in = s;
               if (pending_v) begin
                  // consumer still holds the last frame: drop this capture
                  index_in = '0;
                  phase_in = PH_MEASURE;
               end else begin
                  result.push              = 1'b1;
                  result.word.kind         = KIND_FRAME;
                  result.word.channel      = active_ff;
                  result.word.sample_index = index_ff;
                  result.word.sample_value = s;
                  result.word.frame_last   = last_v;
                  if (last_v) begin
                     index_in   = '0;
                     pending_in = 1'b1;
                     active_in  = active_v;
                     phase_in   = PH_MEASURE;
                     result.word.next_channel = active_v;
                  end else begin
                     index_in = index_ff + 8'd1;
                     result.word.next_channel = active_ff;
                  end
               end
            end
            default: begin
               phase_in = PH_MEASURE;
            end
         endcase
      end

      if (csr_wr_en) begin
         mode_in   = csr_wr_data;
         active_in = (csr_wr_data == MODE_CH2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MEASURE;
         prev_ff    <= '0;
         min_ff     <= 8'hFF;
         max_ff     <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         level_ff   <= '0;
         index_ff   <= '0;
         pending_ff <= 1'b0;
         active_ff  <= 1'b0;
         mode_ff    <= MODE_CH1;
      end else begin
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         level_ff   <= level_in;
         index_ff   <= index_in;
         pending_ff <= pending_in;
         active_ff  <= active_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/stc_out_buf.sv @@
// Two-word result buffer that separates the core from the response channel.
// Depends on stc_pkg for the response word layout.
`default_nettype none

module stc_out_buf
   import stc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output logic            space,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] kept;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign space     = (count_ff != 2'd2);
   assign pop       = rsp_valid & rsp_ready;
   assign kept      = count_ff - {1'b0, pop};

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (result.push) begin
         if (kept == 2'd0) slot0_in = result.word;
         else              slot1_in = result.word;
      end
      count_in = kept + {1'b0, result.push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/scope_trigger_capture.sv @@
// Top level of the scope trigger capture block.
// Instantiates stc_core and stc_out_buf; uses stc_pkg.
`default_nettype none

// One converter sample is taken per request word, one per clock when the
// response side keeps up. Each accepted word is worked in the cycle it is
// accepted: the core updates min, max, sum and trigger state in one pass and
// any result is registered in a two-word output buffer, from which it is
// offered on rsp_valid behind any earlier word. req_ready stays high while a
// finished word waits on rsp_ready and drops only when both buffer slots
// are full. A window of 2^WINDOW_LOG2 samples ends in one measurement word
// (average and peak-to-peak); the block then waits for a falling step, a
// rising step and a sample above the average, and streams FRAME_LEN samples
// tagged with index and last mark. A frame that meets a still-pending frame
// is dropped and measuring restarts. csr_wr_data selects channel one, channel
// two or alternating channels; write it only while the block is idle.
module scope_trigger_capture
   import stc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire channel_mode_type csr_wr_data
);

   result_type result;
   logic       space;
   logic       accept;

   // take a word whenever the buffer has a free slot
   assign req_ready = space;
   assign accept    = req_valid & space;

   stc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   stc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
